@@ hw/rtl/text_terminal_character_writer_assert.svh @@
// Assertion macros of the terminal character writer RTL, included by ttcw_ctrl.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef TEXT_TERMINAL_CHARACTER_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_CHARACTER_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ttcw_pkg.sv @@
// Shared types and constants of the terminal character writer.
// No dependencies; imported by every module of the block.
package ttcw_pkg;

  localparam int DEF_MAX_ROWS    = 32;
  localparam int DEF_MAX_COLUMNS = 128;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LF_AS_CRLF     = 2'd0;
  localparam logic [1:0] CFG_ROWS_IN_USE    = 2'd1;
  localparam logic [1:0] CFG_COLUMNS_IN_USE = 2'd2;

  // Configuration reset values.
  localparam logic       LF_AS_CRLF_RESET     = 1'b1;
  localparam logic [5:0] ROWS_IN_USE_RESET    = 6'd25;
  localparam logic [7:0] COLUMNS_IN_USE_RESET = 8'd80;

  // Color reset values.
  localparam logic [7:0] FG_RESET = 8'd2;
  localparam logic [7:0] BG_RESET = 8'd0;

  // Terminal control bytes.
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_FF = 8'd12;
  localparam logic [7:0] CH_CR = 8'd13;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_FG   = 2'd1,
    CMD_BG   = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0] chr;
    logic [7:0] fg;
    logic [7:0] bg;
  } cell_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_column;
    logic       scrolled;
    cell_t      rd_cell;
  } resp_t;

endpackage

@@ hw/rtl/text_terminal_character_writer.sv @@
// Top level of the terminal character writer: stream ports, configuration
// registers and the result register. Uses ttcw_pkg, ttcw_ctrl, ttcw_cell_mem.
//
//   Channel   Direction  Handshake            Payload
//   in_       sink       in_tvalid/in_tready  in_tuser command, in_tdata byte and read address
//   out_      source     out_tvalid/tready    out_tdata cursor, scroll flag, read cell
//   cfg_      sink       cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Color commands, cell reads, carriage return, backspace and printed bytes pass
// through an execute state against the cell memory and a result state that presents
// the result, and the next item enters as the result is handed over.
// A scroll copies the rows in use up by one and blanks the last row, and a form feed
// blanks all MAX_ROWS * MAX_COLUMNS cells, both swept through the single write port of the cell memory.
// After reset a clearing pass writes zeros to all MAX_ROWS * MAX_COLUMNS cells;
// in_tready stays low until it ends.
// A stalled out_ channel holds one result in the output register while the next
// item executes; the one after that waits until the register drains.
module text_terminal_character_writer #(
  parameter int MAX_ROWS    = ttcw_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = ttcw_pkg::DEF_MAX_COLUMNS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data, [12:8] read_row, [19:13] read_column, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] cursor_row, [11:5] cursor_column, [12] scrolled,
                                  // [20:13] cell_char, [28:21] cell_foreground,
                                  // [36:29] cell_background, [39:37] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ttcw_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int AW = RW + CW;

  logic       lf_as_crlf_r;
  logic [5:0] rows_in_use_r;
  logic [7:0] columns_in_use_r;

  logic          out_valid_r;
  logic [39:0]   out_data_r;

  item_t         item;
  resp_t         resp;
  logic          resp_valid, resp_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  cell_t         mem_wdata, mem_rdata;

  // Configuration writes are always taken; indexes past the register list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_as_crlf_r     <= LF_AS_CRLF_RESET;
      rows_in_use_r    <= ROWS_IN_USE_RESET;
      columns_in_use_r <= COLUMNS_IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LF_AS_CRLF:     lf_as_crlf_r     <= cfg_data[0];
        CFG_ROWS_IN_USE:    rows_in_use_r    <= cfg_data[5:0];
        CFG_COLUMNS_IN_USE: columns_in_use_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Unpack the input beat into the item fields.
  always_comb begin
    item.cmd         = cmd_t'(in_tuser);
    item.data        = in_tdata[7:0];
    item.read_row    = in_tdata[12:8];
    item.read_column = in_tdata[19:13];
  end

  ttcw_ctrl #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_lf_as_crlf     (lf_as_crlf_r),
    .cfg_rows_in_use    (rows_in_use_r),
    .cfg_columns_in_use (columns_in_use_r),
    .item_valid         (in_tvalid),
    .item_ready         (in_tready),
    .item               (item),
    .resp_valid         (resp_valid),
    .resp_ready         (resp_ready),
    .resp               (resp),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata)
  );

  ttcw_cell_mem #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_cell_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register takes a new result whenever it is empty or being drained,
  // so the sequencer never waits on a beat that is already leaving.
  assign resp_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_valid && resp_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      out_data_r <= {3'b000, resp.rd_cell.bg, resp.rd_cell.fg, resp.rd_cell.chr,
                     resp.scrolled, resp.cursor_column, resp.cursor_row};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hw/rtl/ttcw_cell_mem.sv @@
// Screen cell store: one write port, one read port, registered read data.
// Depends on ttcw_pkg for the cell type.
module ttcw_cell_mem #(
  parameter int MAX_ROWS    = ttcw_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = ttcw_pkg::DEF_MAX_COLUMNS,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int AW = RW + CW
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ttcw_pkg::cell_t wdata,
  input  logic [AW-1:0]   raddr,
  output ttcw_pkg::cell_t rdata
);
  import ttcw_pkg::*;

  // Rows are laid out on a power-of-two column pitch.
  localparam int DEPTH = MAX_ROWS * (1 << CW);

  cell_t cells_r [DEPTH];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      cells_r[waddr] <= wdata;
    end
    rdata_r <= cells_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/ttcw_ctrl.sv @@
// Sequencer of the terminal character writer: cursor, colors, item decode
// and the copy, blank and clear sweeps over the cell store. Uses ttcw_pkg.
`include "text_terminal_character_writer_assert.svh"

module ttcw_ctrl #(
  parameter int MAX_ROWS    = ttcw_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = ttcw_pkg::DEF_MAX_COLUMNS,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int AW = RW + CW
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_lf_as_crlf,
  input  logic [5:0]      cfg_rows_in_use,
  input  logic [7:0]      cfg_columns_in_use,
  input  logic            item_valid,
  output logic            item_ready,
  input  ttcw_pkg::item_t item,
  output logic            resp_valid,
  input  logic            resp_ready,
  output ttcw_pkg::resp_t resp,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output ttcw_pkg::cell_t mem_wdata,
  output logic [AW-1:0]   mem_raddr,
  input  ttcw_pkg::cell_t mem_rdata
);
  import ttcw_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_COPY  = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_BLANK = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_t;

  localparam logic [RW-1:0] ROW_END  = RW'(MAX_ROWS - 1);
  localparam logic [CW-1:0] COL_END  = CW'(MAX_COLUMNS - 1);
  localparam logic [6:0]    ROWS_CAP = 7'(MAX_ROWS);
  localparam logic [8:0]    COLS_CAP = 9'(MAX_COLUMNS);

  state_t        state_r, state_nxt;
  item_t         item_r, item_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [7:0]    fg_r, fg_nxt;
  logic [7:0]    bg_r, bg_nxt;
  logic          sc_r, sc_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  cell_t         fill_r, fill_nxt;
  logic          copy_pend_r, copy_pend_nxt;
  logic [AW-1:0] copy_waddr_r, copy_waddr_nxt;
  logic          clear_item_r, clear_item_nxt;

  logic [RW-1:0] last_row, row_sat;
  logic [CW-1:0] last_col, col_sat;
  logic          item_fire, read_ok, do_scroll;
  logic [AW-1:0] read_addr, sweep_addr;
  cell_t         blank;

  // The area in use saturates: zero counts as one, anything above the store as the store.
  always_comb begin
    if (cfg_rows_in_use == 6'd0) begin
      last_row = '0;
    end else if ({1'b0, cfg_rows_in_use} > ROWS_CAP) begin
      last_row = ROW_END;
    end else begin
      last_row = RW'(cfg_rows_in_use - 6'd1);
    end
    if (cfg_columns_in_use == 8'd0) begin
      last_col = '0;
    end else if ({1'b0, cfg_columns_in_use} > COLS_CAP) begin
      last_col = COL_END;
    end else begin
      last_col = CW'(cfg_columns_in_use - 8'd1);
    end
  end

  assign row_sat = (cur_row_r > last_row) ? last_row : cur_row_r;
  assign col_sat = (cur_col_r > last_col) ? last_col : cur_col_r;

  assign item_ready = (state_r == ST_IDLE) || ((state_r == ST_RESP) && resp_ready);
  assign item_fire  = item_valid && item_ready;
  assign resp_valid = (state_r == ST_RESP);

  assign read_ok   = (int'(item_r.read_row) < MAX_ROWS) &&
                     (int'(item_r.read_column) < MAX_COLUMNS);
  assign read_addr  = {RW'(item_r.read_row), CW'(item_r.read_column)};
  assign sweep_addr = {row_cnt_r, col_cnt_r};
  assign blank      = '{chr: 8'd0, fg: fg_r, bg: bg_r};

  // The read port follows the copy sweep, otherwise the addressed cell of the item.
  assign mem_raddr = (state_r == ST_COPY) ? sweep_addr : read_addr;

  always_comb begin
    resp.cursor_row    = 5'(cur_row_r);
    resp.cursor_column = 7'(cur_col_r);
    resp.scrolled      = sc_r;
    resp.rd_cell       = ((item_r.cmd == CMD_READ) && read_ok) ? mem_rdata : '0;
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    fg_nxt         = fg_r;
    bg_nxt         = bg_r;
    sc_nxt         = sc_r;
    row_cnt_nxt    = row_cnt_r;
    col_cnt_nxt    = col_cnt_r;
    fill_nxt       = fill_r;
    clear_item_nxt = clear_item_r;
    copy_pend_nxt  = 1'b0;
    copy_waddr_nxt = {row_cnt_r - 1'b1, col_cnt_r};
    do_scroll      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = sweep_addr;
    mem_wdata      = fill_r;

    // A cell read during the copy sweep is written one row up in the following cycle.
    if (copy_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = copy_waddr_r;
      mem_wdata = mem_rdata;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (col_cnt_r == COL_END) begin
          col_cnt_nxt = '0;
          if (row_cnt_r == ROW_END) begin
            state_nxt = clear_item_r ? ST_RESP : ST_IDLE;
          end else begin
            row_cnt_nxt = row_cnt_r + 1'b1;
          end
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (item_fire) begin
          item_nxt  = item;
          state_nxt = ST_EXEC;
        end
      end
      ST_RESP: begin
        if (resp_ready) begin
          if (item_fire) begin
            item_nxt  = item;
            state_nxt = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EXEC: begin
        sc_nxt         = 1'b0;
        clear_item_nxt = 1'b0;
        state_nxt      = ST_RESP;
        case (item_r.cmd)
          CMD_FG: begin
            fg_nxt = item_r.data;
          end
          CMD_BG: begin
            bg_nxt = item_r.data;
          end
          CMD_READ: begin
            state_nxt = ST_RESP;
          end
          CMD_BYTE: begin
            cur_row_nxt = row_sat;
            cur_col_nxt = col_sat;
            case (item_r.data)
              CH_BS: begin
                if (col_sat != '0) begin
                  cur_col_nxt = col_sat - 1'b1;
                  mem_we      = 1'b1;
                  mem_waddr   = {row_sat, col_sat - 1'b1};
                  mem_wdata   = blank;
                end
              end
              CH_LF: begin
                if (row_sat == last_row) begin
                  do_scroll = 1'b1;
                end else begin
                  cur_row_nxt = row_sat + 1'b1;
                end
                if (cfg_lf_as_crlf) begin
                  cur_col_nxt = '0;
                end
              end
              CH_FF: begin
                cur_row_nxt    = '0;
                cur_col_nxt    = '0;
                fill_nxt       = blank;
                row_cnt_nxt    = '0;
                col_cnt_nxt    = '0;
                clear_item_nxt = 1'b1;
                state_nxt      = ST_CLEAR;
              end
              CH_CR: begin
                cur_col_nxt = '0;
              end
              default: begin
                mem_we    = 1'b1;
                mem_waddr = {row_sat, col_sat};
                mem_wdata = '{chr: item_r.data, fg: fg_r, bg: bg_r};
                if (col_sat == last_col) begin
                  cur_col_nxt = '0;
                  if (row_sat == last_row) begin
                    do_scroll = 1'b1;
                  end else begin
                    cur_row_nxt = row_sat + 1'b1;
                  end
                end else begin
                  cur_col_nxt = col_sat + 1'b1;
                end
              end
            endcase
            if (do_scroll) begin
              sc_nxt      = 1'b1;
              fill_nxt    = blank;
              col_cnt_nxt = '0;
              if (last_row == '0) begin
                row_cnt_nxt = '0;
                state_nxt   = ST_BLANK;
              end else begin
                row_cnt_nxt = RW'(1);
                state_nxt   = ST_COPY;
              end
            end
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      ST_COPY: begin
        copy_pend_nxt = 1'b1;
        if (col_cnt_r == COL_END) begin
          col_cnt_nxt = '0;
          if (row_cnt_r == last_row) begin
            state_nxt = ST_DRAIN;
          end else begin
            row_cnt_nxt = row_cnt_r + 1'b1;
          end
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        row_cnt_nxt = last_row;
        col_cnt_nxt = '0;
        state_nxt   = ST_BLANK;
      end
      ST_BLANK: begin
        mem_we = 1'b1;
        if (col_cnt_r == COL_END) begin
          state_nxt = ST_RESP;
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      fg_r         <= FG_RESET;
      bg_r         <= BG_RESET;
      row_cnt_r    <= '0;
      col_cnt_r    <= '0;
      fill_r       <= '0;
      copy_pend_r  <= 1'b0;
      clear_item_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      fg_r         <= fg_nxt;
      bg_r         <= bg_nxt;
      row_cnt_r    <= row_cnt_nxt;
      col_cnt_r    <= col_cnt_nxt;
      fill_r       <= fill_nxt;
      copy_pend_r  <= copy_pend_nxt;
      clear_item_r <= clear_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    sc_r         <= sc_nxt;
    copy_waddr_r <= copy_waddr_nxt;
  end

  `TTCW_ASSERT_IMP(a_idle_no_write, state_r == ST_IDLE, !mem_we, "cell write while idle")
  `TTCW_ASSERT_IMP(a_drain_has_copy, state_r == ST_DRAIN, copy_pend_r, "drain without copy")
  `TTCW_ASSERT_IMP(a_clear_home, state_r == ST_CLEAR, {cur_row_r, cur_col_r} == '0, "not home")
  `TTCW_ASSERT_IMP(a_scroll_bottom, resp_valid && sc_r, cur_row_r == last_row, "not last row")
  `TTCW_ASSERT_NXT(a_fire_exec, item_fire, state_r == ST_EXEC, "accepted item not executed")

endmodule
